// ===== rtl/nnsp_pkg.sv =====
// Package with shared types, codes and the character check for the septet packer.
`timescale 1ns / 1ps
package nnsp_pkg;

  typedef enum logic [1:0] {
    ROLE_DATA   = 2'd0,
    ROLE_LENGTH = 2'd1,
    ROLE_HEADER = 2'd2
  } role_e;

  localparam int unsigned ResMax   = 4;
  localparam int unsigned ResCntW  = 3;
  localparam logic [7:0]  HdrBase  = 8'h80;

  typedef struct packed {
    logic [7:0] out_byte;
    role_e      role;
    logic       end_of_name;
    logic       encode_error;
  } res_t;

  function automatic logic allowed_char(input logic [7:0] c);
    logic ok;
    ok = (c == 8'h0A) || (c == 8'h0D) ||
         (c inside {[8'h20:8'h3F]}) ||
         (c inside {[8'h41:8'h5A]}) ||
         (c inside {[8'h61:8'h7A]});
    return ok;
  endfunction

endpackage

// ===== rtl/network_name_septet_packer_top.sv =====
// Top level of the network name septet packer: per-name state and result queue.
//
//  channel | direction | signals                                         | accepted when
//  in      | input     | character_i, final_char_i                       | in_valid_i & in_ready_o
//  out     | output    | out_byte_o, byte_role_o, end_of_name_o,
//          |           | encode_error_o                                  | out_valid_o & out_ready_i
//
// Each accepted character's results (none, one, or up to four on the final character)
// are loaded into a four-slot result queue and shown one per cycle while out_ready_i
// is high. A new character is taken while the queue is empty or its last result
// leaves, so a name streams at one character per cycle while the output does not
// stall; after a final character, the next waits until the last of its results leaves.
// Reset clears the packing state and empties the queue. A stall on the output holds
// the queue and closes in_ready_o while any result is queued.
`timescale 1ns / 1ps
module network_name_septet_packer_top #(
  parameter int unsigned MAX_CHARS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] byte_role_o,
  output logic       end_of_name_o,
  output logic       encode_error_o
);

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);

  // Per-name packing state
  logic [7:0]      pending_q, pending_d;
  logic [2:0]      bitpos_q, bitpos_d;
  logic [CntW-1:0] chars_q, chars_d;
  logic [CntW-1:0] octets_q, octets_d;
  logic            failed_q, failed_d;

  // Result queue; slot 0 is at the output
  nnsp_pkg::res_t                   slot_q [nnsp_pkg::ResMax];
  nnsp_pkg::res_t                   slot_d [nnsp_pkg::ResMax];
  logic [nnsp_pkg::ResCntW-1:0]     cnt_q, cnt_d;

  nnsp_pkg::res_t                   res_new [nnsp_pkg::ResMax];
  logic [nnsp_pkg::ResCntW-1:0]     n_new;

  logic        in_fire, out_fire;
  logic        char_bad;
  logic [14:0] acc;
  logic [7:0]  len_byte;
  logic [2:0]  spare;

  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) ||
                       ((cnt_q == nnsp_pkg::ResCntW'(1)) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_byte_o     = slot_q[0].out_byte;
  assign byte_role_o    = slot_q[0].role;
  assign end_of_name_o  = slot_q[0].end_of_name;
  assign encode_error_o = slot_q[0].encode_error;

  assign char_bad = !nnsp_pkg::allowed_char(character_i) ||
                    (chars_q >= CntW'(MAX_CHARS));
  assign acc      = {7'd0, pending_q} | ({8'd0, character_i[6:0]} << bitpos_q);

  // Work out the results of the offered character and the next packing state
  always_comb begin
    pending_d = pending_q;
    bitpos_d  = bitpos_q;
    chars_d   = chars_q;
    octets_d  = octets_q;
    failed_d  = failed_q;
    n_new     = '0;
    len_byte  = '0;
    spare     = '0;
    for (int i = 0; i < nnsp_pkg::ResMax; i++) begin
      res_new[i] = '{out_byte: 8'd0, role: nnsp_pkg::ROLE_DATA,
                     end_of_name: 1'b0, encode_error: 1'b0};
    end

    if (failed_q) begin
      // drop the rest of the name
    end else if (char_bad) begin
      res_new[0] = '{out_byte: 8'd0, role: nnsp_pkg::ROLE_DATA,
                     end_of_name: final_char_i, encode_error: 1'b1};
      n_new      = nnsp_pkg::ResCntW'(1);
      failed_d   = 1'b1;
    end else begin
      chars_d = chars_q + CntW'(1);
      if (bitpos_q != 3'd0) begin
        res_new[0].out_byte = acc[7:0];
        n_new     = nnsp_pkg::ResCntW'(1);
        octets_d  = octets_q + CntW'(1);
        pending_d = {1'b0, acc[14:8]};
        bitpos_d  = bitpos_q - 3'd1;
      end else begin
        pending_d = acc[7:0];
        bitpos_d  = 3'd7;
      end

      if (final_char_i) begin
        len_byte = 8'(octets_d) + 8'd1;
        if (bitpos_d != 3'd0) begin
          res_new[n_new[1:0]].out_byte = pending_d;
          n_new    = n_new + nnsp_pkg::ResCntW'(1);
          len_byte = len_byte + 8'd1;
        end
        res_new[n_new[1:0]].out_byte = len_byte;
        res_new[n_new[1:0]].role     = nnsp_pkg::ROLE_LENGTH;
        n_new = n_new + nnsp_pkg::ResCntW'(1);
        spare = 3'd0 - bitpos_d;
        res_new[n_new[1:0]].out_byte    = nnsp_pkg::HdrBase | {5'd0, spare};
        res_new[n_new[1:0]].role        = nnsp_pkg::ROLE_HEADER;
        res_new[n_new[1:0]].end_of_name = 1'b1;
        n_new = n_new + nnsp_pkg::ResCntW'(1);
      end
    end

    // clear per-name state on the final character
    if (final_char_i) begin
      pending_d = '0;
      bitpos_d  = '0;
      chars_d   = '0;
      octets_d  = '0;
      failed_d  = 1'b0;
    end
  end

  // Load the queue on a new transaction, otherwise advance it on a pop
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (in_fire) begin
      slot_d = res_new;
      cnt_d  = n_new;
    end else if (out_fire) begin
      for (int i = 0; i < nnsp_pkg::ResMax - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      cnt_d = cnt_q - nnsp_pkg::ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      bitpos_q  <= '0;
      chars_q   <= '0;
      octets_q  <= '0;
      failed_q  <= 1'b0;
      cnt_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        pending_q <= pending_d;
        bitpos_q  <= bitpos_d;
        chars_q   <= chars_d;
        octets_q  <= octets_d;
        failed_q  <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ===== rtl/nnsp_checker.sv =====
// Port-level checker for the septet packer, bound to the top level.
`timescale 1ns / 1ps
module nnsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] byte_role_o,
  input logic       end_of_name_o,
  input logic       encode_error_o
);

  // An error result carries no octet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && encode_error_o |->
      out_byte_o == 8'd0 && byte_role_o == nnsp_pkg::ROLE_DATA)
    else $error("error result carries data");

  // A clean name ends only on a header octet with a valid spare count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_name_o && !encode_error_o |->
      byte_role_o == nnsp_pkg::ROLE_HEADER && out_byte_o[7:3] == 5'b10000)
    else $error("name ended without header octet");

  // The length octet is followed at once by the header octet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && byte_role_o == nnsp_pkg::ROLE_LENGTH |=>
      out_valid_o && byte_role_o == nnsp_pkg::ROLE_HEADER)
    else $error("length octet not followed by header");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(byte_role_o))
    else $error("stalled result changed");

endmodule

bind network_name_septet_packer_top nnsp_checker u_nnsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .byte_role_o    (byte_role_o),
  .end_of_name_o  (end_of_name_o),
  .encode_error_o (encode_error_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the network name septet packer: directed table plus random names.
`timescale 1ns / 1ps
module testbench;

  localparam int NAME_MAX    = 10;
  localparam int RAND_ITEMS  = 185;
  localparam int IDLE_LIMIT  = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] character_i = 8'h00;
  logic       final_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] byte_role_o;
  logic       end_of_name_o;
  logic       encode_error_o;

  network_name_septet_packer_top #(
    .MAX_CHARS(NAME_MAX)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .character_i   (character_i),
    .final_char_i  (final_char_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_role_o   (byte_role_o),
    .end_of_name_o (end_of_name_o),
    .encode_error_o(encode_error_o)
  );

  always #2 clk_i = ~clk_i;

  typedef struct {
    logic [7:0]      ch;
    logic            fin;
    int              n_fixed;   // -1: take the packing predictor's octets
    nnsp_pkg::res_t  fixed [3];
  } row_t;

  row_t           stim_rows [$];
  nnsp_pkg::res_t octet_q [$];
  int   mismatches = 0;
  int   octets_seen = 0;

  // packing state of the name in flight
  logic [7:0] held_bits;
  logic [2:0] fill;
  logic [6:0] char_cnt;
  logic [6:0] octet_cnt;
  logic       name_bad;

  function automatic nnsp_pkg::res_t mk_res(input logic [7:0] v, input nnsp_pkg::role_e role,
                                            input logic eon, input logic err);
    nnsp_pkg::res_t r;
    r.out_byte     = v;
    r.role         = role;
    r.end_of_name  = eon;
    r.encode_error = err;
    return r;
  endfunction

  function automatic logic is_legal(input logic [7:0] c);
    return (c == 8'h0A) || (c == 8'h0D) || (c >= 8'h20 && c <= 8'h3F) ||
           (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] legal_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = 8'h0A;
      1: c = 8'h0D;
      2, 3, 4: c = 8'($urandom_range(8'h20, 8'h3F));
      5, 6, 7: c = 8'($urandom_range(8'h41, 8'h5A));
      default: c = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] illegal_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_legal(c));
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic restart_name();
    held_bits = 8'h00;
    fill      = 3'd0;
    char_cnt  = 7'd0;
    octet_cnt = 7'd0;
    name_bad  = 1'b0;
  endtask

  // Advance the packing state by one character; queue its octets when record is set.
  task automatic pack_char(input logic [7:0] ch, input logic fin, input bit record);
    logic [15:0]    acc;
    logic [7:0]     data_cnt;
    logic [2:0]     spare;
    nnsp_pkg::res_t emit [$];
    if (name_bad) begin
      if (fin) restart_name();
    end else if (!is_legal(ch) || char_cnt >= NAME_MAX) begin
      emit.push_back(mk_res(8'h00, nnsp_pkg::ROLE_DATA, fin, 1'b1));
      if (fin) restart_name();
      else name_bad = 1'b1;
    end else begin
      char_cnt = char_cnt + 7'd1;
      acc = {8'h00, held_bits} | ({9'h000, ch[6:0]} << fill);
      if (fill != 3'd0) begin
        emit.push_back(mk_res(acc[7:0], nnsp_pkg::ROLE_DATA, 1'b0, 1'b0));
        octet_cnt = octet_cnt + 7'd1;
        held_bits = acc[15:8];
        fill      = fill - 3'd1;
      end else begin
        held_bits = acc[7:0];
        fill      = 3'd7;
      end
      if (fin) begin
        data_cnt = {1'b0, octet_cnt};
        if (fill != 3'd0) begin
          emit.push_back(mk_res(held_bits, nnsp_pkg::ROLE_DATA, 1'b0, 1'b0));
          data_cnt = data_cnt + 8'd1;
        end
        spare = 3'd0 - fill;
        emit.push_back(mk_res(data_cnt + 8'd1, nnsp_pkg::ROLE_LENGTH, 1'b0, 1'b0));
        emit.push_back(mk_res(nnsp_pkg::HdrBase | {5'b00000, spare}, nnsp_pkg::ROLE_HEADER,
                              1'b1, 1'b0));
        restart_name();
      end
    end
    if (record) begin
      foreach (emit[k]) octet_q.push_back(emit[k]);
    end
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic fin, input int n,
                         input nnsp_pkg::res_t a = '0, input nnsp_pkg::res_t b = '0,
                         input nnsp_pkg::res_t c = '0);
    row_t r;
    r.ch       = ch;
    r.fin      = fin;
    r.n_fixed  = n;
    r.fixed[0] = a;
    r.fixed[1] = b;
    r.fixed[2] = c;
    stim_rows.push_back(r);
  endtask

  // Hold the character on the bus until the transaction is taken.
  task automatic offer(input logic [7:0] ch, input logic fin, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    character_i  <= ch;
    final_char_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // output checker
  always @(posedge clk_i) begin : check_out
    nnsp_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      octets_seen++;
      if (octet_q.size() == 0) begin
        report("unexpected result", out_byte_o, 8'h00);
      end else begin
        want = octet_q.pop_front();
        if (out_byte_o !== want.out_byte) report("out_byte", out_byte_o, want.out_byte);
        if (byte_role_o !== want.role) report("byte_role", {6'b0, byte_role_o}, {6'b0, want.role});
        if (end_of_name_o !== want.end_of_name)
          report("end_of_name", {7'b0, end_of_name_o}, {7'b0, want.end_of_name});
        if (encode_error_o !== want.encode_error)
          report("encode_error", {7'b0, encode_error_o}, {7'b0, want.encode_error});
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up into its input
  initial begin : receiver
    bit held;
    int g;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && octets_seen >= 30) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("network_name_septet_packer_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int         items_done;
    int         kind;
    int         len;
    int         bad_at;
    bit         burst;
    logic [7:0] c;
    logic       fin;

    restart_name();

    // single-character name, invalid finals, error then dropped tail
    add_row(8'h41, 1'b1, 3, mk_res(8'h41, nnsp_pkg::ROLE_DATA, 1'b0, 1'b0),
            mk_res(8'h02, nnsp_pkg::ROLE_LENGTH, 1'b0, 1'b0),
            mk_res(8'h81, nnsp_pkg::ROLE_HEADER, 1'b1, 1'b0));
    add_row(8'h00, 1'b1, 1, mk_res(8'h00, nnsp_pkg::ROLE_DATA, 1'b1, 1'b1));
    add_row(8'hFF, 1'b1, 1, mk_res(8'h00, nnsp_pkg::ROLE_DATA, 1'b1, 1'b1));
    add_row(8'h40, 1'b0, 1, mk_res(8'h00, nnsp_pkg::ROLE_DATA, 1'b0, 1'b1));
    add_row(8'h41, 1'b0, 0);
    add_row(8'h7B, 1'b1, 0);
    // eight characters: the septets end exactly on an octet boundary
    add_row(8'h0A, 1'b0, -1);
    add_row(8'h0D, 1'b0, -1);
    add_row(8'h20, 1'b0, -1);
    add_row(8'h3F, 1'b0, -1);
    add_row(8'h41, 1'b0, -1);
    add_row(8'h5A, 1'b0, -1);
    add_row(8'h61, 1'b0, -1);
    add_row(8'h7A, 1'b1, -1);
    // longest name, then one character too many on the final
    add_row(8'h7A, 1'b0, -1);
    add_row(8'h61, 1'b0, -1);
    add_row(8'h5A, 1'b0, -1);
    add_row(8'h41, 1'b0, -1);
    add_row(8'h3F, 1'b0, -1);
    add_row(8'h20, 1'b0, -1);
    add_row(8'h0D, 1'b0, -1);
    add_row(8'h0A, 1'b0, -1);
    add_row(8'h55, 1'b0, -1);
    add_row(8'h2A, 1'b0, -1);
    add_row(8'h20, 1'b1, 1, mk_res(8'h00, nnsp_pkg::ROLE_DATA, 1'b1, 1'b1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      offer(stim_rows[i].ch, stim_rows[i].fin, pick_gap());
      pack_char(stim_rows[i].ch, stim_rows[i].fin, stim_rows[i].n_fixed < 0);
      for (int j = 0; j < stim_rows[i].n_fixed; j++) octet_q.push_back(stim_rows[i].fixed[j]);
    end

    // random names: mostly well-formed, some noise, overlong or with one bad character
    items_done = 0;
    while (items_done < RAND_ITEMS) begin
      burst  = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 19);
      len    = (kind == 2 || kind == 3) ? $urandom_range(NAME_MAX + 1, NAME_MAX + 3)
                                        : $urandom_range(1, NAME_MAX);
      bad_at = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
        if (kind <= 1) c = 8'($urandom_range(0, 255));
        else if ((kind == 4 || kind == 5) && k == bad_at) c = illegal_char();
        else c = legal_char();
        fin = (k == len - 1);
        offer(c, fin, burst ? 0 : pick_gap());
        items_done++;
        pack_char(c, fin, 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    while (octet_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("network_name_septet_packer_top regression: pass");
    end else begin
      $display("network_name_septet_packer_top regression: fail");
    end
    $finish;
  end

endmodule
